// ===== rtl/binned_multi_reduction_defines.svh =====
// Assertion macros, clocked on clock and disabled while reset is high.
`ifndef BINNED_MULTI_REDUCTION_DEFINES_SVH
`define BINNED_MULTI_REDUCTION_DEFINES_SVH

`ifndef SYNTHESIS

`define BMR_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("binned_multi_reduction: assertion failed");

`define BMR_ASSERT_IMPL(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("binned_multi_reduction: assertion failed");

`define BMR_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("binned_multi_reduction: assertion failed");

`else

`define BMR_ASSERT(lbl, expr)

`define BMR_ASSERT_IMPL(lbl, pre, post)

`define BMR_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== rtl/bmr_pkg.sv =====
`default_nettype none

package bmr_pkg;

   localparam int BIN_COUNT   = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int BIN_WIDTH   = 4;
   localparam int OP_WIDTH    = 2;
   localparam int CFG_WIDTH   = 5;

   localparam logic [CFG_WIDTH-1:0] BINS_RESET = CFG_WIDTH'(16);

   localparam logic [OP_WIDTH-1:0] OP_ACCUM = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_READ  = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_CLEAR = 2'd2;

   localparam logic [VALUE_WIDTH-1:0] ID_SUM = '0;
   localparam logic [VALUE_WIDTH-1:0] ID_MIN = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] ID_MAX = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic [VALUE_WIDTH-1:0] ID_AND = '1;
   localparam logic [VALUE_WIDTH-1:0] ID_OR  = '0;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] sum_v;
      logic [VALUE_WIDTH-1:0] min_v;
      logic [VALUE_WIDTH-1:0] max_v;
      logic [VALUE_WIDTH-1:0] and_v;
      logic [VALUE_WIDTH-1:0] or_v;
   } entry_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] sum_out;
      logic [VALUE_WIDTH-1:0] min_out;
      logic [VALUE_WIDTH-1:0] max_out;
      logic [VALUE_WIDTH-1:0] and_out;
      logic [VALUE_WIDTH-1:0] or_out;
      logic                   bad_bin;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/bmr_req_if.sv =====
`default_nettype none

interface bmr_req_if;
   import bmr_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [OP_WIDTH-1:0]           op;
   logic [BIN_WIDTH-1:0]          bin_index;
   logic signed [VALUE_WIDTH-1:0] sample_value;

   modport source (output valid, output op, output bin_index, output sample_value,
                   input ready);
   modport sink   (input valid, input op, input bin_index, input sample_value,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/bmr_rsp_if.sv =====
`default_nettype none

interface bmr_rsp_if;
   import bmr_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] sum_out;
   logic signed [VALUE_WIDTH-1:0] min_out;
   logic signed [VALUE_WIDTH-1:0] max_out;
   logic [VALUE_WIDTH-1:0]        and_out;
   logic [VALUE_WIDTH-1:0]        or_out;
   logic                          bad_bin;

   modport source (output valid, output sum_out, output min_out, output max_out,
                   output and_out, output or_out, output bad_bin, input ready);
   modport sink   (input valid, input sum_out, input min_out, input max_out,
                   input and_out, input or_out, input bad_bin, output ready);
endinterface

`default_nettype wire

// ===== rtl/bmr_ram.sv =====
`default_nettype none

module bmr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-before-write on a shared address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bmr_fold.sv =====
`default_nettype none

module bmr_fold (
   input  logic                            first,
   input  bmr_pkg::entry_type              cur,
   input  logic [bmr_pkg::VALUE_WIDTH-1:0] value,
   output bmr_pkg::entry_type              next
);
   import bmr_pkg::*;

   always_comb begin
      if (first) begin
         next.sum_v = value;
         next.min_v = value;
         next.max_v = value;
         next.and_v = value;
         next.or_v  = value;
      end else begin
         next.sum_v = cur.sum_v + value;
         next.min_v = ($signed(value) < $signed(cur.min_v)) ? value : cur.min_v;
         next.max_v = ($signed(cur.max_v) < $signed(value)) ? value : cur.max_v;
         next.and_v = cur.and_v & value;
         next.or_v  = cur.or_v | value;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/binned_multi_reduction.sv =====
// A read item passes the update stage, then its result is offered from the output register.
// Throughput: one item per cycle unless stalled; bin memory is read at accept, written back by
// the update stage; a same-bin follow-on item takes the last write from a bypass register.
// A read result held at the output stalls a following read in the update stage and the input.
// Reset (synchronous): valid marks cleared at once, bins_ff set to 16, no clearing pass.
`default_nettype none

`include "binned_multi_reduction_defines.svh"

module binned_multi_reduction (
   input  logic                          clock,
   input  logic                          reset,
   bmr_req_if.sink                       req_ch,
   bmr_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [bmr_pkg::CFG_WIDTH-1:0] csr_wr_data
);
   import bmr_pkg::*;

   logic [CFG_WIDTH-1:0]   bins_ff, bins_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic [OP_WIDTH-1:0]    s1_op_ff;
   logic [BIN_WIDTH-1:0]   s1_bin_ff;
   logic [VALUE_WIDTH-1:0] s1_value_ff;
   logic [BIN_COUNT-1:0]   bin_valid_ff, bin_valid_in;
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [BIN_WIDTH-1:0]   fwd_bin_ff;
   entry_type              fwd_entry_ff;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;

   logic [$bits(entry_type)-1:0] ram_rd_bits;
   entry_type              ram_rdata, cur_entry, next_entry;
   logic                   req_fire, s1_is_read, s1_advance, s1_fire;
   logic                   in_range, wr_en, out_load, fwd_hit;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign s1_is_read = (s1_op_ff == OP_READ);
   assign s1_advance = !s1_is_read || !out_valid_ff || rsp_ch.ready;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_ch.ready = !s1_valid_ff || s1_advance;

   assign in_range = ({1'b0, s1_bin_ff} < bins_ff) &&
                     ({1'b0, s1_bin_ff} < CFG_WIDTH'(BIN_COUNT));

   // last write is always the freshest copy of its bin
   assign ram_rdata = entry_type'(ram_rd_bits);
   assign fwd_hit   = fwd_valid_ff && (fwd_bin_ff == s1_bin_ff);
   assign cur_entry = fwd_hit ? fwd_entry_ff : ram_rdata;

   assign wr_en    = s1_fire && (s1_op_ff == OP_ACCUM) && in_range;
   assign out_load = s1_fire && s1_is_read;

   bmr_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (BIN_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_bin_ff),
      .wr_data (next_entry),
      .rd_en   (req_fire),
      .rd_addr (req_ch.bin_index),
      .rd_data (ram_rd_bits)
   );

   bmr_fold u_fold (
      .first (!bin_valid_ff[s1_bin_ff]),
      .cur   (cur_entry),
      .value (s1_value_ff),
      .next  (next_entry)
   );

   always_comb begin
      bins_in      = csr_wr_en ? csr_wr_data : bins_ff;
      s1_valid_in  = req_fire || (s1_valid_ff && !s1_advance);
      fwd_valid_in = fwd_valid_ff || wr_en;
      out_valid_in = out_load || (out_valid_ff && !rsp_ch.ready);

      bin_valid_in = bin_valid_ff;
      if (s1_fire) begin
         case (s1_op_ff)
            OP_CLEAR: bin_valid_in = '0;
            OP_ACCUM: begin
               if (in_range) begin
                  bin_valid_in[s1_bin_ff] = 1'b1;
               end
            end
            default: bin_valid_in = bin_valid_ff;
         endcase
      end

      if (!in_range) begin
         out_in         = '0;
         out_in.bad_bin = 1'b1;
      end else if (bin_valid_ff[s1_bin_ff]) begin
         out_in.sum_out = cur_entry.sum_v;
         out_in.min_out = cur_entry.min_v;
         out_in.max_out = cur_entry.max_v;
         out_in.and_out = cur_entry.and_v;
         out_in.or_out  = cur_entry.or_v;
         out_in.bad_bin = 1'b0;
      end else begin
         out_in.sum_out = ID_SUM;
         out_in.min_out = ID_MIN;
         out_in.max_out = ID_MAX;
         out_in.and_out = ID_AND;
         out_in.or_out  = ID_OR;
         out_in.bad_bin = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff      <= BINS_RESET;
         s1_valid_ff  <= 1'b0;
         bin_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         bins_ff      <= bins_in;
         s1_valid_ff  <= s1_valid_in;
         bin_valid_ff <= bin_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= req_ch.op;
         s1_bin_ff   <= req_ch.bin_index;
         s1_value_ff <= req_ch.sample_value;
      end
      if (wr_en) begin
         fwd_bin_ff   <= s1_bin_ff;
         fwd_entry_ff <= next_entry;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.sum_out = out_ff.sum_out;
   assign rsp_ch.min_out = out_ff.min_out;
   assign rsp_ch.max_out = out_ff.max_out;
   assign rsp_ch.and_out = out_ff.and_out;
   assign rsp_ch.or_out  = out_ff.or_out;
   assign rsp_ch.bad_bin = out_ff.bad_bin;

   `BMR_ASSERT_IMPL(a_write_only_accum, wr_en, s1_valid_ff && (s1_op_ff == OP_ACCUM))
   `BMR_ASSERT_NEXT(a_write_sets_valid, wr_en, bin_valid_ff[$past(s1_bin_ff)])
   `BMR_ASSERT_NEXT(a_clear_drops_all, s1_fire && (s1_op_ff == OP_CLEAR), bin_valid_ff == '0)
   `BMR_ASSERT_NEXT(a_read_gives_item, out_load, out_valid_ff)
   `BMR_ASSERT_IMPL(a_bad_bin_zero, out_valid_ff && out_ff.bad_bin,
                    (out_ff.sum_out == '0) && (out_ff.min_out == '0) &&
                    (out_ff.max_out == '0) && (out_ff.and_out == '0) &&
                    (out_ff.or_out == '0))

endmodule

`default_nettype wire
